// File: rtl/sdspi_pkg.sv
// Shared types and constants for the SD card SPI-mode host sequencer.
package sdspi_pkg;

	// Request codes carried in req_type.
	localparam logic [2:0] REQ_INIT  = 3'd0;
	localparam logic [2:0] REQ_READ  = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_SYNC  = 3'd3;
	localparam logic [2:0] REQ_CARD  = 3'd4;
	localparam logic [2:0] REQ_WBYTE = 3'd5;
	localparam logic [2:0] REQ_TICK  = 3'd6;

	// Completion status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ERROR    = 2'd1;
	localparam logic [1:0] ST_PARAM    = 2'd2;
	localparam logic [1:0] ST_NOTREADY = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_INIT_TIMEOUT = 1'b0;
	localparam logic CFG_POLL_LIMIT   = 1'b1;

	localparam int unsigned BLOCK_BYTES = 512;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  drive_number;
		logic [31:0] block_address;
		logic [7:0]  block_count;
		logic [7:0]  card_byte;
		logic [7:0]  write_byte;
	} req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       cs_active;
		logic       data_request;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic [1:0] status;
		logic       initialized;
		logic [1:0] card_type;
	} rsp_t;

	typedef struct packed {
		logic [15:0] init_timeout_ms;
		logic [7:0]  response_poll_limit;
	} cfg_t;

endpackage

// File: rtl/sdspi_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface sdspi_req_if;
	import sdspi_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdspi_rsp_if;
	import sdspi_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sdspi_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/sdspi_core.sv
// Sequencer state and next-state logic: state updates once per stepped transaction.
module sdspi_core #(
	parameter int unsigned DUMMY_BYTES = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sdspi_pkg::req_t   req,
	input  sdspi_pkg::cfg_t   cfg,
	output sdspi_pkg::rsp_t   rsp
);
	import sdspi_pkg::*;

	localparam logic [4:0] PH_IDLE = 5'd0, PH_WAIT_POWER = 5'd1, PH_DUMMY = 5'd2,
		PH_WAIT_SETTLE = 5'd3, PH_WAIT_SELECT = 5'd4, PH_PRE_CMD0 = 5'd5,
		PH_FRAME = 5'd6, PH_POLL = 5'd7, PH_GAP = 5'd8, PH_TRAIL = 5'd9,
		PH_RD_TOKEN = 5'd10, PH_RD_DATA = 5'd11, PH_RD_CRC = 5'd12,
		PH_WR_TOKEN = 5'd13, PH_WR_NEED = 5'd14, PH_WR_DATA = 5'd15,
		PH_WR_CRC = 5'd16, PH_WR_RESP = 5'd17, PH_WR_BUSY = 5'd18, PH_SYNC = 5'd19;

	localparam logic [5:0] CMD0 = 6'd0, CMD8 = 6'd8, CMD17 = 6'd17, CMD24 = 6'd24,
		CMD41 = 6'd41, CMD55 = 6'd55, CMD58 = 6'd58;

	localparam logic [9:0] DUMMY_N = 10'(DUMMY_BYTES);
	localparam logic [9:0] BLOCK_N = 10'(BLOCK_BYTES);

	logic [4:0]  phase_q, phase_d;
	logic [9:0]  bc_q, bc_d;
	logic [7:0]  poll_q, poll_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  resp_q, resp_d;
	logic [7:0]  ocr_q [4];
	logic        ocr_we;
	logic [31:0] arg_q, arg_d;
	logic        app_q, app_d;
	logic [1:0]  type_q, type_d;
	logic        rdy_q, rdy_d;
	logic [5:0]  cmd_q, cmd_d;
	logic        cs_q, cs_d;
	rsp_t        o;

	// Byte of the command frame at position k.
	function automatic logic [7:0] frame_byte(input logic [9:0] k, input logic [5:0] c,
		input logic [31:0] a);
		case (k)
			10'd0: frame_byte = 8'hFF;
			10'd1: frame_byte = {2'b01, c};
			10'd2: frame_byte = a[31:24];
			10'd3: frame_byte = a[23:16];
			10'd4: frame_byte = a[15:8];
			10'd5: frame_byte = a[7:0];
			default: frame_byte = (c == CMD0) ? 8'h95 : (c == CMD8) ? 8'h87 : 8'h01;
		endcase
	endfunction

	always_comb begin
		phase_d = phase_q; bc_d = bc_q; poll_d = poll_q; tick_d = tick_q;
		resp_d = resp_q; arg_d = arg_q; app_d = app_q; type_d = type_q;
		rdy_d = rdy_q; cmd_d = cmd_q; cs_d = cs_q; ocr_we = 1'b0;
		o = '0;
		case (req.req_type)
			REQ_INIT, REQ_READ, REQ_WRITE, REQ_SYNC: begin
				if (phase_q == PH_IDLE) begin
					if (req.req_type == REQ_INIT) begin
						if (req.drive_number != 8'd0) begin
							o.done_res = 1'b1; o.status = ST_NOTREADY; cs_d = 1'b0;
						end else begin
							rdy_d = 1'b0; type_d = 2'd0; cs_d = 1'b0; tick_d = '0;
							phase_d = PH_WAIT_POWER;
						end
					end else if (req.drive_number != 8'd0 ||
						(req.req_type != REQ_SYNC && req.block_count == 8'd0)) begin
						o.done_res = 1'b1; o.status = ST_PARAM; cs_d = 1'b0;
					end else if (!rdy_q) begin
						o.done_res = 1'b1; o.status = ST_NOTREADY; cs_d = 1'b0;
					end else if (req.req_type == REQ_SYNC) begin
						cs_d = 1'b1; phase_d = PH_SYNC; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end else if (req.block_count > 8'd1) begin
						o.done_res = 1'b1; o.status = ST_ERROR; cs_d = 1'b0;
					end else begin
						cmd_d = (req.req_type == REQ_READ) ? CMD17 : CMD24;
						arg_d = (type_q != 2'd3) ? {req.block_address[22:0], 9'd0}
							: req.block_address;
						cs_d = 1'b1; bc_d = '0; phase_d = PH_FRAME;
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
				end
			end
			REQ_CARD: begin
				case (phase_q)
					PH_DUMMY: begin
						bc_d = bc_q + 10'd1;
						if (bc_d < DUMMY_N) begin
							o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						end else begin
							tick_d = '0; phase_d = PH_WAIT_SETTLE;
						end
					end
					PH_PRE_CMD0: begin
						cmd_d = CMD0; arg_d = '0; cs_d = 1'b1; bc_d = '0; phase_d = PH_FRAME;
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
					PH_FRAME: begin
						bc_d = bc_q + 10'd1;
						o.tx_valid = 1'b1;
						if (bc_d < 10'd7) o.tx_byte = frame_byte(bc_d, cmd_q, arg_q);
						else begin
							poll_d = cfg.response_poll_limit; phase_d = PH_POLL;
							o.tx_byte = 8'hFF;
						end
					end
					PH_POLL: begin
						resp_d = req.card_byte;
						poll_d = poll_q - 8'd1;
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						if (!(req.card_byte[7] && poll_d != 8'd0)) begin
							// Command response received or polling exhausted.
							case (cmd_q)
								CMD55: begin
									app_d = 1'b0;
									if (req.card_byte > 8'd1) begin
										cmd_d = CMD41; cs_d = 1'b0; phase_d = PH_GAP;
									end else begin
										cmd_d = CMD41; arg_d = 32'h4000_0000; cs_d = 1'b1;
										bc_d = '0; phase_d = PH_FRAME;
									end
								end
								CMD8, CMD58: begin
									bc_d = '0; phase_d = PH_TRAIL;
								end
								CMD17: begin
									if (req.card_byte == 8'd0) phase_d = PH_RD_TOKEN;
									else begin
										o = '0; o.done_res = 1'b1; o.status = ST_ERROR;
										phase_d = PH_IDLE; cs_d = 1'b0;
									end
								end
								CMD24: begin
									if (req.card_byte == 8'd0) begin
										bc_d = '0; phase_d = PH_WR_TOKEN;
									end else begin
										o = '0; o.done_res = 1'b1; o.status = ST_ERROR;
										phase_d = PH_IDLE; cs_d = 1'b0;
									end
								end
								default: begin
									cs_d = 1'b0; phase_d = PH_GAP;
								end
							endcase
						end
					end
					PH_TRAIL: begin
						ocr_we = 1'b1;
						bc_d = bc_q + 10'd1;
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						if (bc_d >= 10'd4) begin
							cs_d = 1'b0; phase_d = PH_GAP;
						end
					end
					PH_GAP: begin
						if (cmd_q == CMD0) begin
							if (resp_q != 8'h01) begin
								o.done_res = 1'b1; o.status = ST_NOTREADY;
								phase_d = PH_IDLE; cs_d = 1'b0;
							end else begin
								cmd_d = CMD8; arg_d = 32'h0000_01AA; cs_d = 1'b1; bc_d = '0;
								phase_d = PH_FRAME; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
							end
						end else if (cmd_q == CMD8) begin
							if (resp_q == 8'h01 && ocr_q[2] == 8'h01 && ocr_q[3] == 8'hAA) begin
								tick_d = '0; app_d = 1'b1; cmd_d = CMD55; arg_d = '0;
								cs_d = 1'b1; bc_d = '0; phase_d = PH_FRAME;
								o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
							end else begin
								o.done_res = 1'b1; o.status = ST_NOTREADY;
								phase_d = PH_IDLE; cs_d = 1'b0;
							end
						end else if (cmd_q == CMD41) begin
							if (tick_q > cfg.init_timeout_ms) begin
								o.done_res = 1'b1; o.status = ST_NOTREADY;
								phase_d = PH_IDLE; cs_d = 1'b0;
							end else begin
								if (resp_q != 8'd0) begin
									app_d = 1'b1; cmd_d = CMD55;
									arg_d = '0;
								end else begin
									cmd_d = CMD58; arg_d = '0;
								end
								cs_d = 1'b1; bc_d = '0; phase_d = PH_FRAME;
								o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
							end
						end else begin
							o.done_res = 1'b1; phase_d = PH_IDLE; cs_d = 1'b0;
							if (resp_q != 8'd0) o.status = ST_NOTREADY;
							else begin
								type_d = ocr_q[0][6] ? 2'd3 : 2'd2;
								rdy_d = 1'b1; o.status = ST_OK;
							end
						end
					end
					PH_RD_TOKEN: begin
						if (req.card_byte == 8'hFE) begin
							bc_d = '0; phase_d = PH_RD_DATA;
						end
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
					PH_RD_DATA: begin
						o.read_valid = 1'b1; o.read_byte = req.card_byte;
						bc_d = bc_q + 10'd1;
						if (bc_q == BLOCK_N - 10'd1) begin
							bc_d = '0; phase_d = PH_RD_CRC;
						end
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
					PH_RD_CRC: begin
						bc_d = bc_q + 10'd1;
						if (bc_d < 10'd2) begin
							o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						end else begin
							o.done_res = 1'b1; o.status = ST_OK; phase_d = PH_IDLE; cs_d = 1'b0;
						end
					end
					PH_WR_TOKEN: begin
						bc_d = bc_q + 10'd1;
						if (bc_d == 10'd1) begin
							o.tx_valid = 1'b1; o.tx_byte = 8'hFE;
						end else begin
							bc_d = '0; phase_d = PH_WR_NEED; o.data_request = 1'b1;
						end
					end
					PH_WR_DATA: begin
						bc_d = bc_q + 10'd1;
						if (bc_q != BLOCK_N - 10'd1) begin
							phase_d = PH_WR_NEED; o.data_request = 1'b1;
						end else begin
							bc_d = '0; phase_d = PH_WR_CRC; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						end
					end
					PH_WR_CRC: begin
						bc_d = bc_q + 10'd1;
						if (bc_d >= 10'd2) phase_d = PH_WR_RESP;
						o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
					PH_WR_RESP: begin
						if (req.card_byte[4:0] == 5'h05) begin
							phase_d = PH_WR_BUSY; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						end else begin
							o.done_res = 1'b1; o.status = ST_ERROR; phase_d = PH_IDLE; cs_d = 1'b0;
						end
					end
					PH_WR_BUSY: begin
						if (req.card_byte == 8'd0) begin
							o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
						end else begin
							o.done_res = 1'b1; o.status = ST_OK; phase_d = PH_IDLE; cs_d = 1'b0;
						end
					end
					PH_SYNC: begin
						o.done_res = 1'b1; phase_d = PH_IDLE; cs_d = 1'b0;
						o.status = (req.card_byte == 8'hFF) ? ST_OK : ST_ERROR;
					end
					default: ;
				endcase
			end
			REQ_WBYTE: begin
				if (phase_q == PH_WR_NEED) begin
					phase_d = PH_WR_DATA; o.tx_valid = 1'b1; o.tx_byte = req.write_byte;
				end
			end
			REQ_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_q != 16'hFFFF) tick_d = tick_q + 16'd1;
					if (phase_q == PH_WAIT_POWER && tick_d >= 16'd10) begin
						bc_d = '0; phase_d = PH_DUMMY; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end else if (phase_q == PH_WAIT_SETTLE && tick_d >= 16'd10) begin
						tick_d = '0; cs_d = 1'b1; phase_d = PH_WAIT_SELECT;
					end else if (phase_q == PH_WAIT_SELECT && tick_d >= 16'd1) begin
						cs_d = 1'b0; phase_d = PH_PRE_CMD0; o.tx_valid = 1'b1; o.tx_byte = 8'hFF;
					end
				end
			end
			default: ;
		endcase
		o.cs_active = cs_d;
		o.initialized = rdy_d;
		o.card_type = type_d;
	end

	assign rsp = o;

	// Control state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; bc_q <= '0; poll_q <= '0; tick_q <= '0; resp_q <= '0;
			arg_q <= '0; app_q <= 1'b0; type_q <= '0; rdy_q <= 1'b0; cmd_q <= CMD0;
			cs_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d; bc_q <= bc_d; poll_q <= poll_d; tick_q <= tick_d;
			resp_q <= resp_d; arg_q <= arg_d; app_q <= app_d; type_q <= type_d;
			rdy_q <= rdy_d; cmd_q <= cmd_d; cs_q <= cs_d;
		end
	end

	// OCR and CMD8 trailing bytes.
	always_ff @(posedge clk) begin
		if (step && ocr_we) ocr_q[bc_q[1:0]] <= req.card_byte;
	end

endmodule

// File: rtl/sd_spi_mode_host_sequencer.sv
// Top level of the SD card SPI-mode host sequencer.
//
// Channels: "in" carries one transaction per request, card byte, write byte
// or millisecond tick; "out" returns exactly one result transaction for each
// input transaction, in order; "cfg" writes the timeout (index 0) and the
// response poll limit (index 1), and is always ready.
// Each input transaction is registered, evaluated combinationally by the
// sequencer and its result placed in an output register, from which it is
// offered; one transaction can be accepted every cycle while the output
// register drains.
// The input register accepts whenever it is empty or its contents move on in
// the same cycle; a stalled receiver holds the result and then the input
// register, and "in" ready falls until the result is taken.
// Reset clears the phase, counters, chip select and the ready flag, and
// loads the timeout with 1000 ticks and the poll limit with 10 reads.
module sd_spi_mode_host_sequencer #(
	parameter int unsigned DUMMY_BYTES = 10
) (
	input logic clk,
	input logic arst_n,
	sdspi_req_if.sink   in,
	sdspi_rsp_if.source out,
	sdspi_cfg_if.sink   cfg
);
	import sdspi_pkg::*;

	req_t req_s1;
	logic v_s1;
	rsp_t rsp_s2, rsp_c;
	logic v_s2;
	cfg_t cfg_q;
	logic adv;

	assign adv = v_s1 && (!v_s2 || out.ready);
	assign in.ready = !v_s1 || adv;
	assign cfg.ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in.ready) v_s1 <= in.valid;
	end
	always_ff @(posedge clk) begin
		if (in.valid && in.ready) req_s1 <= in.data;
	end

	sdspi_core #(.DUMMY_BYTES(DUMMY_BYTES)) u_core (
		.clk(clk), .arst_n(arst_n), .step(adv), .req(req_s1), .cfg(cfg_q), .rsp(rsp_c)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= 1'b1;
		else if (out.ready) v_s2 <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (adv) rsp_s2 <= rsp_c;
	end
	assign out.valid = v_s2;
	assign out.data = rsp_s2;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_timeout_ms <= 16'd1000;
			cfg_q.response_poll_limit <= 8'd10;
		end else if (cfg.valid && cfg.index == {7'd0, CFG_INIT_TIMEOUT}) begin
			cfg_q.init_timeout_ms <= cfg.wdata[15:0];
		end else if (cfg.valid && cfg.index == {7'd0, CFG_POLL_LIMIT}) begin
			cfg_q.response_poll_limit <= cfg.wdata[7:0];
		end
	end

	// A completed transaction never carries both read data and a write request.
	a_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !(rsp_s2.read_valid && rsp_s2.data_request)) else $error("rd and wr");
	// A held result stays while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !out.ready) |=> (v_s2 && $stable(rsp_s2))) else $error("result lost");
	// A core step always leaves a valid result in the result register.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_s2) else $error("result missing");

endmodule
